// File: rtl/fpwc_pkg.sv
// ----------------------------------------------------------------------------
// Flash page write combiner package
// Sizes, field positions and codes shared by the write combiner.
// ----------------------------------------------------------------------------
package fpwc_pkg;

	localparam int PAGE_BYTES  = 128;
	localparam int FLASH_BYTES = 8192;
	localparam int BYTE_W      = 8;

	localparam int ADDR_W   = $clog2(FLASH_BYTES);
	localparam int REND_W   = ADDR_W + 1;
	localparam int OFF_W    = $clog2(PAGE_BYTES);
	localparam int WORDS    = PAGE_BYTES / 2;
	localparam int WIDX_W   = OFF_W - 1;
	localparam int PAGES    = FLASH_BYTES / PAGE_BYTES;
	localparam int PIDX_W   = ADDR_W - OFF_W;
	localparam int IMG_AW   = PIDX_W + WIDX_W;
	localparam int IMG_ROWS = PAGES * WORDS;
	localparam int PWORD_W  = 2 * BYTE_W;

	localparam int ACT_W  = 2;
	localparam int KIND_W = 1;

	localparam int S_FIELDS_W = ADDR_W + REND_W + BYTE_W;
	localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = ADDR_W + WIDX_W + PWORD_W;
	localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [ACT_W-1:0] {
		ACT_OPEN  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_SKIP  = 2'd2,
		ACT_CLOSE = 2'd3
	} action_t;

	localparam logic [KIND_W-1:0] KIND_WORD = 1'b0;
	localparam logic [KIND_W-1:0] KIND_ERR  = 1'b1;

	localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

endpackage

// File: rtl/flash_page_write_combiner.sv
// ----------------------------------------------------------------------------
// Flash page write combiner
// Collects byte writes into a page buffer and programs the page only when it
// differs from the flash contents.
// ----------------------------------------------------------------------------
// Open, skip and a write that does not complete a page are taken in the idle
// state, which stays ready for the next item. A write or skip that completes the
// page, or a close inside a page, starts a compare pass that reads the buffer and
// image memories one 16-bit word per cycle; if the page changed, a second pass
// emits one programming word per cycle and writes the image back, slowed only by
// m_tready. A write or skip beyond the region end moves to an error state that
// returns its error item once the output is free. The image needs no clearing
// after reset: a flip-flop per page marks pages never programmed, which read as erased.
module flash_page_write_combiner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fpwc_pkg::S_DATA_W-1:0] s_tdata,  // address, region_end, data_byte
	input  logic [fpwc_pkg::ACT_W-1:0]    s_tuser,  // action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fpwc_pkg::M_DATA_W-1:0] m_tdata,  // page_address, word_index, program_word
	output logic [fpwc_pkg::KIND_W-1:0]   m_tuser,  // kind
	output logic                          m_tlast
);
	import fpwc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CMP  = 5'b00010,
		ST_CMPE = 5'b00100,
		ST_EMIT = 5'b01000,
		ST_ERR  = 5'b10000
	} state_t;

	state_t              state_q;
	logic                is_open_q;
	logic [PIDX_W-1:0]   page_idx_q;
	logic [OFF_W-1:0]    fill_q;
	logic [REND_W-1:0]   limit_q;
	logic                adv_q;
	logic                diff_q;
	logic [WIDX_W-1:0]   idx_q;
	logic                iss_done_q;
	logic [WORDS-1:0]    mask_lo_q;
	logic [WORDS-1:0]    mask_hi_q;
	logic [PAGES-1:0]    pv_q;

	logic                cmp_v_s1;
	logic                emit_v_s1;
	logic [WIDX_W-1:0]   idx_s1;
	logic                last_s1;
	logic                mlo_s1;
	logic                mhi_s1;
	logic                pv_s1;
	logic [BYTE_W-1:0]   buf_lo_s1;
	logic [BYTE_W-1:0]   buf_hi_s1;
	logic [BYTE_W-1:0]   img_lo_s1;
	logic [BYTE_W-1:0]   img_hi_s1;

	logic                out_v_q;
	logic [KIND_W-1:0]   out_kind_q;
	logic [ADDR_W-1:0]   out_page_q;
	logic [WIDX_W-1:0]   out_widx_q;
	logic [PWORD_W-1:0]  out_word_q;
	logic                out_last_q;

	logic [BYTE_W-1:0]   buf_lo_mem [WORDS];
	logic [BYTE_W-1:0]   buf_hi_mem [WORDS];
	logic [BYTE_W-1:0]   img_lo_mem [IMG_ROWS];
	logic [BYTE_W-1:0]   img_hi_mem [IMG_ROWS];

	action_t             act;
	logic [ADDR_W-1:0]   in_addr;
	logic [REND_W-1:0]   in_rend;
	logic [BYTE_W-1:0]   in_data;
	logic                acc;
	logic                out_free;
	logic [ADDR_W-1:0]   page_base;
	logic [ADDR_W-1:0]   byte_addr;
	logic                beyond;
	logic                buf_we;
	logic [BYTE_W-1:0]   img_eff_lo;
	logic [BYTE_W-1:0]   img_eff_hi;
	logic [BYTE_W-1:0]   mrg_lo;
	logic [BYTE_W-1:0]   mrg_hi;
	logic                mismatch;
	logic                diff_now;
	logic                emit_move;
	logic                cmp_issue;
	logic                emit_issue;
	logic                rd_en;
	logic                is_last_idx;
	logic                done_flush;
	logic [IMG_AW-1:0]   img_raddr;
	logic [IMG_AW-1:0]   img_waddr;

	assign act      = action_t'(s_tuser);
	assign in_addr  = s_tdata[ADDR_W-1:0];
	assign in_rend  = s_tdata[ADDR_W+REND_W-1:ADDR_W];
	assign in_data  = s_tdata[S_FIELDS_W-1:ADDR_W+REND_W];

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign out_free = !out_v_q || m_tready;

	assign page_base = {page_idx_q, {OFF_W{1'b0}}};
	assign byte_addr = {page_idx_q, fill_q};
	assign beyond    = (limit_q != '0) && ({1'b0, byte_addr} >= limit_q);
	assign buf_we    = acc && (act == ACT_WRITE) && is_open_q && !beyond;

	// Unwritten buffer bytes stand for the image; unprogrammed pages read erased.
	assign img_eff_lo = pv_s1 ? img_lo_s1 : ERASED_BYTE;
	assign img_eff_hi = pv_s1 ? img_hi_s1 : ERASED_BYTE;
	assign mrg_lo     = mlo_s1 ? buf_lo_s1 : img_eff_lo;
	assign mrg_hi     = mhi_s1 ? buf_hi_s1 : img_eff_hi;
	assign mismatch   = (mlo_s1 && (buf_lo_s1 != img_eff_lo)) ||
	                    (mhi_s1 && (buf_hi_s1 != img_eff_hi));
	assign diff_now   = diff_q || mismatch;

	assign is_last_idx = (idx_q == WIDX_W'(WORDS - 1));
	assign emit_move   = emit_v_s1 && out_free;
	assign cmp_issue   = (state_q == ST_CMP);
	assign emit_issue  = (state_q == ST_EMIT) && !iss_done_q && (!emit_v_s1 || emit_move);
	assign rd_en       = cmp_issue || emit_issue;
	assign done_flush  = ((state_q == ST_CMPE) && !diff_now) || (emit_move && last_s1);
	assign img_raddr   = {page_idx_q, idx_q};
	assign img_waddr   = {page_idx_q, idx_s1};

	always_ff @(posedge clk) begin
		if (buf_we) begin
			if (fill_q[0]) begin
				buf_hi_mem[fill_q[OFF_W-1:1]] <= in_data;
			end else begin
				buf_lo_mem[fill_q[OFF_W-1:1]] <= in_data;
			end
		end
		if (rd_en) begin
			buf_lo_s1 <= buf_lo_mem[idx_q];
			buf_hi_s1 <= buf_hi_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (emit_move) begin
			img_lo_mem[img_waddr] <= mrg_lo;
			img_hi_mem[img_waddr] <= mrg_hi;
		end
		if (rd_en) begin
			img_lo_s1 <= img_lo_mem[img_raddr];
			img_hi_s1 <= img_hi_mem[img_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1  <= idx_q;
			last_s1 <= is_last_idx;
			mlo_s1  <= mask_lo_q[idx_q];
			mhi_s1  <= mask_hi_q[idx_q];
			pv_s1   <= pv_q[page_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			is_open_q  <= 1'b0;
			page_idx_q <= '0;
			fill_q     <= '0;
			limit_q    <= '0;
			adv_q      <= 1'b0;
			diff_q     <= 1'b0;
			idx_q      <= '0;
			iss_done_q <= 1'b0;
			mask_lo_q  <= '0;
			mask_hi_q  <= '0;
			pv_q       <= '0;
			cmp_v_s1   <= 1'b0;
			emit_v_s1  <= 1'b0;
		end else begin
			cmp_v_s1 <= cmp_issue;
			if (cmp_v_s1) begin
				diff_q <= diff_now;
			end
			if (emit_issue) begin
				emit_v_s1 <= 1'b1;
			end else if (emit_move) begin
				emit_v_s1 <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (act) inside
							ACT_OPEN: begin
								page_idx_q <= in_addr[ADDR_W-1:OFF_W];
								fill_q     <= in_addr[OFF_W-1:0];
								limit_q    <= in_rend;
								is_open_q  <= 1'b1;
								mask_lo_q  <= '0;
								mask_hi_q  <= '0;
							end
							ACT_CLOSE: begin
								if (is_open_q) begin
									if (fill_q != '0) begin
										adv_q   <= 1'b0;
										diff_q  <= 1'b0;
										idx_q   <= '0;
										state_q <= ST_CMP;
									end else begin
										is_open_q <= 1'b0;
									end
								end
							end
							ACT_WRITE, ACT_SKIP: begin
								if (is_open_q) begin
									if (beyond) begin
										state_q <= ST_ERR;
									end else begin
										if (act == ACT_WRITE) begin
											if (fill_q[0]) begin
												mask_hi_q[fill_q[OFF_W-1:1]] <= 1'b1;
											end else begin
												mask_lo_q[fill_q[OFF_W-1:1]] <= 1'b1;
											end
										end
										if (fill_q == OFF_W'(PAGE_BYTES - 1)) begin
											adv_q   <= 1'b1;
											diff_q  <= 1'b0;
											idx_q   <= '0;
											state_q <= ST_CMP;
										end else begin
											fill_q <= fill_q + 1'b1;
										end
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_CMP: begin
					idx_q <= idx_q + 1'b1;
					if (is_last_idx) begin
						state_q <= ST_CMPE;
					end
				end
				ST_CMPE: begin
					if (diff_now) begin
						idx_q      <= '0;
						iss_done_q <= 1'b0;
						state_q    <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_issue) begin
						idx_q <= idx_q + 1'b1;
						if (is_last_idx) begin
							iss_done_q <= 1'b1;
						end
					end
					if (emit_move && last_s1) begin
						pv_q[page_idx_q] <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				ST_ERR: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (done_flush) begin
				fill_q <= '0;
				if (adv_q) begin
					page_idx_q <= page_idx_q + 1'b1;
					mask_lo_q  <= '0;
					mask_hi_q  <= '0;
				end else begin
					is_open_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit_move || ((state_q == ST_ERR) && out_free)) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_move) begin
			out_kind_q <= KIND_WORD;
			out_page_q <= page_base;
			out_widx_q <= idx_s1;
			out_word_q <= {mrg_hi, mrg_lo};
			out_last_q <= last_s1;
		end else if ((state_q == ST_ERR) && out_free) begin
			out_kind_q <= KIND_ERR;
			out_page_q <= page_base;
			out_widx_q <= '0;
			out_word_q <= '0;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(M_DATA_W - M_FIELDS_W){1'b0}}, out_word_q, out_widx_q, out_page_q};

	a_emit_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		emit_v_s1 |-> (state_q == ST_EMIT))
		else $error("Emit stage holds a word outside the emit pass.");

	a_cmp_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_v_s1 |-> (state_q == ST_CMP || state_q == ST_CMPE))
		else $error("Compare stage active outside the compare pass.");

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_ERR)) |-> m_tlast)
		else $error("Error item without last flag.");

	a_closed_no_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!is_open_q |-> (fill_q == '0))
		else $error("Fill offset nonzero while no page is open.");

endmodule

// File: test/fpwc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash page write combiner checker
// Watches both stream channels, keeps its own copy of the page buffer and the
// flash image, predicts the programming words and region errors of every
// accepted item and compares them in order with the items the block emits.
// ----------------------------------------------------------------------------
module fpwc_checker
	import fpwc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic [ACT_W-1:0]    s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [M_DATA_W-1:0] m_tdata,
	input  logic [KIND_W-1:0]   m_tuser,
	input  logic                m_tlast,
	output int                  mismatches,
	output int                  pending,
	output int                  words_checked,
	output int                  errors_checked
);

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [ADDR_W-1:0]  page_address;
		logic [WIDX_W-1:0]  word_index;
		logic [PWORD_W-1:0] program_word;
		logic               last;
	} flash_result_t;

	flash_result_t      expected_results[$];

	logic [BYTE_W-1:0]  flash_img [FLASH_BYTES];
	logic [BYTE_W-1:0]  page_buf [PAGE_BYTES];
	bit                 page_open;
	int                 page_base;
	int                 fill_off;
	int                 limit_addr;

	initial begin
		mismatches = 0;
		pending = 0;
		words_checked = 0;
		errors_checked = 0;
		page_open = 1'b0;
		page_base = 0;
		fill_off = 0;
		limit_addr = 0;
		foreach (flash_img[i]) flash_img[i] = ERASED_BYTE;
		foreach (page_buf[i]) page_buf[i] = '0;
	end

	task automatic load_buffer(input int from);
		for (int i = from; i < PAGE_BYTES; i++)
			page_buf[i] = flash_img[(page_base + i) % FLASH_BYTES];
	endtask

	// A page is programmed only when at least one byte differs from the image.
	task automatic program_page();
		bit            changed;
		flash_result_t r;
		changed = 1'b0;
		for (int i = 0; i < PAGE_BYTES; i++)
			if (page_buf[i] !== flash_img[(page_base + i) % FLASH_BYTES])
				changed = 1'b1;
		if (!changed)
			return;
		for (int w = 0; w < WORDS; w++) begin
			r.kind = KIND_WORD;
			r.page_address = ADDR_W'(page_base);
			r.word_index = WIDX_W'(w);
			r.program_word = {page_buf[2*w+1], page_buf[2*w]};
			r.last = (w == WORDS - 1);
			expected_results.push_back(r);
		end
		for (int i = 0; i < PAGE_BYTES; i++)
			flash_img[(page_base + i) % FLASH_BYTES] = page_buf[i];
	endtask

	task automatic combine_item(input action_t act, input int addr, input int rend,
			input logic [BYTE_W-1:0] data);
		flash_result_t r;
		if (act == ACT_OPEN) begin
			fill_off = addr % PAGE_BYTES;
			page_base = addr - fill_off;
			load_buffer(0);
			limit_addr = rend;
			page_open = 1'b1;
		end else if (page_open) begin
			if (act == ACT_CLOSE) begin
				if (fill_off != 0) begin
					load_buffer(fill_off);
					program_page();
				end
				page_open = 1'b0;
				fill_off = 0;
			end else if (limit_addr != 0 && page_base + fill_off >= limit_addr) begin
				r.kind = KIND_ERR;
				r.page_address = ADDR_W'(page_base);
				r.word_index = '0;
				r.program_word = '0;
				r.last = 1'b1;
				expected_results.push_back(r);
			end else begin
				if (act == ACT_WRITE)
					page_buf[fill_off] = data;
				fill_off++;
				if (fill_off >= PAGE_BYTES) begin
					program_page();
					page_base += PAGE_BYTES;
					if (page_base >= FLASH_BYTES)
						page_base = 0;
					load_buffer(0);
					fill_off = 0;
				end
			end
		end
	endtask

	task automatic report_mismatch(input string what, input flash_result_t exp_r,
			input flash_result_t act_r);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected kind %0d page %0h word %0d data %4h last %0d, got kind %0d page %0h word %0d data %4h last %0d",
				$realtime, what, exp_r.kind, exp_r.page_address, exp_r.word_index,
				exp_r.program_word, exp_r.last, act_r.kind, act_r.page_address,
				act_r.word_index, act_r.program_word, act_r.last);
	endtask

	// The output is checked before the input of the same edge is predicted, so an
	// item can never be matched against results of an item accepted with it.
	always @(posedge clk) begin
		flash_result_t seen;
		flash_result_t exp_r;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen.kind = m_tuser;
				seen.page_address = m_tdata[ADDR_W-1:0];
				seen.word_index = m_tdata[ADDR_W +: WIDX_W];
				seen.program_word = m_tdata[ADDR_W+WIDX_W +: PWORD_W];
				seen.last = m_tlast;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected item", '0, seen);
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r.kind == KIND_ERR)
						errors_checked++;
					else
						words_checked++;
					if (seen.kind !== exp_r.kind)
						report_mismatch("kind mismatch", exp_r, seen);
					else if (seen.page_address !== exp_r.page_address)
						report_mismatch("page address mismatch", exp_r, seen);
					else if (seen.word_index !== exp_r.word_index)
						report_mismatch("word index mismatch", exp_r, seen);
					else if (seen.program_word !== exp_r.program_word)
						report_mismatch("program word mismatch", exp_r, seen);
					else if (seen.last !== exp_r.last)
						report_mismatch("last flag mismatch", exp_r, seen);
				end
			end
			if (s_tvalid && s_tready)
				combine_item(action_t'(s_tuser), int'(s_tdata[ADDR_W-1:0]),
					int'(s_tdata[ADDR_W +: REND_W]), s_tdata[ADDR_W+REND_W +: BYTE_W]);
			pending <= expected_results.size();
		end
	end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash page write combiner testbench
// Drives directed and random open, write, skip and close items with random
// gaps on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	import fpwc_pkg::*;

	localparam int RANDOM_ITEMS = 430;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 300;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [ACT_W-1:0]    s_tuser = ACT_OPEN;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]   m_tuser;
	logic                m_tlast;

	int mismatches;
	int pending;
	int words_checked;
	int errors_checked;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int stall_cycles = 0;
	int items_sent = 0;
	int random_items = 0;
	bit session_open = 1'b0;

	flash_page_write_combiner u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	fpwc_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.mismatches     (mismatches),
		.pending        (pending),
		.words_checked  (words_checked),
		.errors_checked (errors_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("Timeout: nothing accepted for %0d cycles", STALL_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic send_item(input action_t act, input logic [ADDR_W-1:0] addr,
			input logic [REND_W-1:0] rend, input logic [BYTE_W-1:0] data);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {{(S_DATA_W-S_FIELDS_W){1'b0}}, data, rend, addr};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		if (act == ACT_OPEN || session_open)
			random_items++;
		if (act == ACT_OPEN)
			session_open = 1'b1;
		else if (act == ACT_CLOSE)
			session_open = 1'b0;
	endtask

	task automatic set_pressure();
		if (items_sent < RANDOM_ITEMS / 3) begin
			src_idle_pct = 6;
			sink_idle_pct = 47;
		end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
			src_idle_pct = 47;
			sink_idle_pct = 6;
		end else begin
			src_idle_pct = 0;
			sink_idle_pct = 0;
		end
	endtask

	// Most sessions open near the end of a page so that runs complete pages;
	// some set a region end a few bytes past the start to provoke errors.
	task automatic random_session();
		int                  offset;
		int                  start;
		int                  run_len;
		int                  write_pct;
		logic [REND_W-1:0]   rend;
		logic [BYTE_W-1:0]   data;
		if ($urandom_range(99) < 85) begin
			offset = ($urandom_range(3) == 0) ? $urandom_range(PAGE_BYTES - 1)
				: $urandom_range(PAGE_BYTES - 1, PAGE_BYTES - 38);
			start = $urandom_range(PAGES - 1) * PAGE_BYTES + offset;
			case ($urandom_range(9))
				0, 1: rend = REND_W'(start + $urandom_range(1, 40));
				2: rend = REND_W'($urandom_range(FLASH_BYTES));
				default: rend = '0;
			endcase
			if (rend > FLASH_BYTES)
				rend = REND_W'(FLASH_BYTES);
			send_item(ACT_OPEN, ADDR_W'(start), rend, BYTE_W'($urandom));
			write_pct = ($urandom_range(3) == 0) ? 0 : 75;
			run_len = $urandom_range(1, 45);
			repeat (run_len) begin
				data = ($urandom_range(3) == 0) ? ERASED_BYTE : BYTE_W'($urandom);
				if ($urandom_range(99) < write_pct)
					send_item(ACT_WRITE, ADDR_W'($urandom), REND_W'($urandom), data);
				else
					send_item(ACT_SKIP, ADDR_W'($urandom), REND_W'($urandom), data);
			end
			if ($urandom_range(99) < 60)
				send_item(ACT_CLOSE, ADDR_W'($urandom), REND_W'($urandom), BYTE_W'($urandom));
		end else begin
			repeat ($urandom_range(1, 4))
				send_item(action_t'($urandom_range(3)), ADDR_W'($urandom_range(FLASH_BYTES - 1)),
					REND_W'($urandom_range(FLASH_BYTES)), BYTE_W'($urandom));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle_pct = 6;
		sink_idle_pct = 47;

		send_item(ACT_CLOSE, '0, '0, 8'h00);
		send_item(ACT_WRITE, 13'h1FFF, 14'd8192, 8'hFF);
		send_item(ACT_SKIP, 13'h1FFF, 14'd8192, 8'hFF);
		send_item(ACT_OPEN, 13'd8190, 14'd0, 8'h00);
		send_item(ACT_WRITE, '0, '0, 8'h00);
		send_item(ACT_WRITE, '0, '0, 8'hFF);
		send_item(ACT_WRITE, '0, '0, 8'hA5);
		send_item(ACT_CLOSE, '0, '0, 8'h00);
		send_item(ACT_OPEN, 13'd8190, 14'd0, 8'h00);
		send_item(ACT_SKIP, '0, '0, 8'h00);
		send_item(ACT_SKIP, '0, '0, 8'h00);
		send_item(ACT_CLOSE, '0, '0, 8'h00);
		send_item(ACT_OPEN, 13'd5, 14'd6, 8'h00);
		send_item(ACT_WRITE, '0, '0, 8'h3C);
		send_item(ACT_WRITE, '0, '0, 8'h11);
		send_item(ACT_SKIP, '0, '0, 8'h00);
		send_item(ACT_CLOSE, '0, '0, 8'h00);
		send_item(ACT_OPEN, 13'd300, 14'd8192, 8'h00);
		send_item(ACT_WRITE, '0, '0, 8'h55);
		send_item(ACT_OPEN, 13'd127, 14'd0, 8'h00);
		send_item(ACT_WRITE, '0, '0, 8'hFF);
		send_item(ACT_OPEN, 13'h1FFF, 14'd0, 8'h00);
		send_item(ACT_WRITE, '0, '0, 8'h12);
		send_item(ACT_CLOSE, '0, '0, 8'h00);

		random_items = 0;
		while (items_sent < RANDOM_ITEMS) begin
			set_pressure();
			random_session();
		end
		s_tvalid <= 1'b0;
		src_idle_pct = 0;
		sink_idle_pct = 0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items, %0d of them in random sessions.", items_sent, random_items);
		$display("Checked %0d programming words and %0d region errors.",
			words_checked, errors_checked);
		if (mismatches == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
